// File: design/drc_pkg.sv
// Shared types and constants for the datagram receive checker.
`default_nettype none

package drc_pkg;

    // Header layout: flags word, checksum word, then the size word.
    localparam int HEADER_BYTES   = 8;
    localparam int FLAGS_END      = 2;
    localparam int CHECKSUM_END   = 4;

    // The sequence bit is masked out of the flags comparison.
    localparam logic [15:0] FLAGS_SEQ_MASK = 16'hFF7F;
    localparam int          SEQ_BIT        = 7;

    // Width of the reported payload length.
    localparam int PLEN_W = 10;

    // Status codes reported on the last byte of a datagram.
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_SHORT     = 2'd1;
    localparam status_t STATUS_SIZE_ERR  = 2'd2;
    localparam status_t STATUS_CSUM_ERR  = 2'd3;

    // One result transaction.
    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic              packet_done;
        status_t           check_status;
        logic              flags_match;
        logic              send_ack;
        logic              ack_number;
        logic [PLEN_W-1:0] payload_length;
    } drc_result_t;

endpackage

`default_nettype wire

// File: design/drc_parse.sv
// Header parser, payload checksum accumulator and end-of-datagram checks.
`default_nettype none

module drc_parse #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic [15:0]        match_flags,
    output drc_pkg::drc_result_t    result
);
    import drc_pkg::*;

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [15:0]   flags_reg, flags_next;
    logic [15:0]   checksum_reg, checksum_next;
    logic [31:0]   size_reg, size_next;
    logic [15:0]   xor_reg, xor_next;
    logic [7:0]    pending_reg, pending_next;

    logic          in_range;
    logic          is_payload;
    logic [CW-1:0] payload_pos;
    logic [31:0]   npay;
    logic [15:0]   sum;
    status_t       status;
    logic          size_ok;
    logic          header_ok;

    // Fold the current byte into the per-datagram state.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        flags_next      = flags_reg;
        checksum_next   = checksum_reg;
        size_next       = size_reg;
        xor_next        = xor_reg;
        pending_next    = pending_reg;
        in_range        = byte_count_reg < CW'(MAX_PACKET_BYTES);
        is_payload      = 1'b0;
        payload_pos     = byte_count_reg - CW'(HEADER_BYTES);
        if (in_range)
        begin
            priority if (byte_count_reg < CW'(FLAGS_END))
            begin
                flags_next = {flags_reg[7:0], data_byte};
            end
            else if (byte_count_reg < CW'(CHECKSUM_END))
            begin
                checksum_next = {checksum_reg[7:0], data_byte};
            end
            else if (byte_count_reg < CW'(HEADER_BYTES))
            begin
                size_next = {size_reg[23:0], data_byte};
            end
            else
            begin
                is_payload = 1'b1;
                if (!payload_pos[0])
                begin
                    pending_next = data_byte;
                end
                else
                begin
                    xor_next = xor_reg ^ {pending_reg, data_byte};
                end
            end
            byte_count_next = byte_count_reg + CW'(1);
        end
    end

    // Checks made on the last byte, using the state including this byte.
    always_comb
    begin
        npay      = 32'(byte_count_next) - 32'(HEADER_BYTES);
        header_ok = byte_count_next >= CW'(HEADER_BYTES);
        sum       = flags_next ^ size_next[15:0] ^ xor_next;
        if (npay[0])
        begin
            sum = sum ^ {pending_next, 8'h00};
        end
        size_ok = 32'(byte_count_next) == size_next;
        priority if (!header_ok)
        begin
            status = STATUS_SHORT;
        end
        else if (!size_ok)
        begin
            status = STATUS_SIZE_ERR;
        end
        else if (sum != checksum_next)
        begin
            status = STATUS_CSUM_ERR;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // Assemble the result transaction.
    always_comb
    begin
        result                = '0;
        result.payload_valid  = is_payload;
        result.payload_byte   = is_payload ? data_byte : 8'h00;
        result.packet_done    = last_byte;
        if (last_byte)
        begin
            result.check_status = status;
            if (header_ok)
            begin
                result.flags_match    = (flags_next & FLAGS_SEQ_MASK) == match_flags;
                result.send_ack       = 1'b1;
                result.ack_number     = flags_next[SEQ_BIT] ^ (status != STATUS_OK);
                result.payload_length = npay[PLEN_W-1:0];
            end
        end
    end

    // Per-datagram state; the last byte returns it to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            flags_reg      <= '0;
            checksum_reg   <= '0;
            size_reg       <= '0;
            xor_reg        <= '0;
            pending_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_count_reg <= '0;
                flags_reg      <= '0;
                checksum_reg   <= '0;
                size_reg       <= '0;
                xor_reg        <= '0;
                pending_reg    <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                flags_reg      <= flags_next;
                checksum_reg   <= checksum_next;
                size_reg       <= size_next;
                xor_reg        <= xor_next;
                pending_reg    <= pending_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/drc_out_reg.sv
// Output register holding one result transaction until downstream takes it.
`default_nettype none

module drc_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  drc_pkg::drc_result_t      result_in,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic                      busy,
    output drc_pkg::drc_result_t      result_out
);
    import drc_pkg::*;

    logic        valid_reg;
    drc_result_t result_reg;

    // The register can take a new result when empty or when being drained.
    assign busy       = valid_reg && out_stall;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

// File: design/datagram_receive_checker.sv
// Top level of the datagram receive checker.
// Each result is registered and appears in the cycle after its byte transaction is accepted.
// Throughput: one byte per cycle; the single output register sets the limit,
// and a new byte is taken whenever that register is empty or being drained.
// Reset clears the per-datagram state, the output valid and the expected flags.
`default_nettype none

module datagram_receive_checker #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] expected_data_flags,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic             packet_done,
    output logic [1:0]       check_status,
    output logic             flags_match,
    output logic             send_ack,
    output logic             ack_number,
    output logic [9:0]       payload_length
);
    import drc_pkg::*;

    logic        accept;
    logic        out_busy;
    logic [15:0] match_flags_reg;
    drc_result_t result_comb;
    drc_result_t result_q;

    // Input handshake.
    assign in_stall  = out_busy;
    assign accept    = in_valid && !out_busy;
    assign cfg_ready = 1'b1;

    // Expected flags register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_flags_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            match_flags_reg <= expected_data_flags;
        end
    end

    drc_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .match_flags    (match_flags_reg),
        .result         (result_comb)
    );

    drc_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (result_comb),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .busy       (out_busy),
        .result_out (result_q)
    );

    // Result fields.
    assign payload_valid  = result_q.payload_valid;
    assign payload_byte   = result_q.payload_byte;
    assign packet_done    = result_q.packet_done;
    assign check_status   = result_q.check_status;
    assign flags_match    = result_q.flags_match;
    assign send_ack       = result_q.send_ack;
    assign ack_number     = result_q.ack_number;
    assign payload_length = result_q.payload_length;

endmodule

`default_nettype wire

// File: design/drc_checker.sv
// Port-level assertions for the datagram receive checker, bound to the top level.
`default_nettype none

module drc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       packet_done,
    input wire logic [1:0] check_status,
    input wire logic       flags_match,
    input wire logic       send_ack,
    input wire logic       ack_number,
    input wire logic [9:0] payload_length
);
    import drc_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Every accepted byte produces a result on the next cycle.
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted byte produced no result");

    // Status fields stay zero on results that do not end a datagram.
    a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !packet_done |->
            check_status == STATUS_OK && !send_ack && !flags_match && payload_length == '0)
        else $error("status reported before the last byte");

    // A short header gets no acknowledge and no flags match.
    a_short_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_done && check_status == STATUS_SHORT |->
            !send_ack && !flags_match && payload_length == '0)
        else $error("acknowledge on a short header");

    // The acknowledge number is zero without an acknowledge.
    a_ackno_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_ack |-> !ack_number)
        else $error("acknowledge number set without acknowledge");

endmodule

bind datagram_receive_checker drc_checker u_drc_checker (.*);

`default_nettype wire
